// File: rtl/core/btp_pkg.sv
// Shared types and constants for the basic timer peripheral.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package btp_pkg;

    localparam logic [31:0] LOW16       = 32'h0000_FFFF;
    localparam logic [11:0] LAST_OFFSET = 12'h050;
    localparam logic [11:0] ALIGN_MASK  = 12'h003;

    localparam int REG_WORDS = 21;
    localparam int DEC_WORDS = int'(LAST_OFFSET[11:2]) + 1;
    localparam int IDX_W     = $clog2((REG_WORDS > DEC_WORDS) ? REG_WORDS : DEC_WORDS);

    localparam logic [IDX_W-1:0] W_CTRL   = IDX_W'(0);
    localparam logic [IDX_W-1:0] W_IE     = IDX_W'(3);
    localparam logic [IDX_W-1:0] W_STATUS = IDX_W'(4);
    localparam logic [IDX_W-1:0] W_EVENT  = IDX_W'(5);
    localparam logic [IDX_W-1:0] W_COUNT  = IDX_W'(9);
    localparam logic [IDX_W-1:0] W_PRESC  = IDX_W'(10);
    localparam logic [IDX_W-1:0] W_RELOAD = IDX_W'(11);

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] byte_offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
        logic [7:0]  tick_count;
        logic        clock_on;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_ok;
        logic        update_request;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic tick;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic tick_go;
        logic ticks_zero;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/core/basic_timer_peripheral.sv
// Basic timer peripheral top level: prescaler, auto-reload counter, 21 word registers.
// Bus access: accepted on start; execute state, then the result strobe in response state.
// Tick batch with the counter running: tick_count timer cycles, one timer cycle per clock
// through the single prescaler/counter update path; otherwise no timer cycles run.
// busy stays high until the result strobe; the receiver cannot stall the result.
// Synchronous active-low reset clears the registers (reload word 0xFFFF) and prescaler.
`timescale 1ns / 1ps
`default_nettype none

module basic_timer_peripheral
    import btp_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    input  t_in  i_item,
    output t_out o_result,
    output logic o_strobe
);

    t_cmd w_cmd;
    t_sts w_sts;

    btp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    btp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_sts    (w_sts),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// File: rtl/core/btp_ctrl.sv
// Controller state machine: accept a beat, run the tick loop, present the result.
// Depends on btp_pkg; drives btp_dp through t_cmd and watches t_sts.
`timescale 1ns / 1ps
`default_nettype none

module btp_ctrl
    import btp_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_strobe
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        busy     = 1'b1;
        o_strobe = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.tick_go && !i_sts.ticks_zero) begin
                    o_cmd.tick = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_RESP;
                end
            end
            ST_RESP: begin
                o_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RESP |=> r_state == ST_IDLE)
        else $error("result not followed by idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_EXEC)
        else $error("accepted beat did not enter execution");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// File: rtl/core/btp_dp.sv
// Datapath: register file, prescaler, counter update and result register.
// Depends on btp_pkg; commanded by btp_ctrl through t_cmd.
`timescale 1ns / 1ps
`default_nettype none

module btp_dp
    import btp_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_item,
    output t_sts o_sts,
    output t_out o_result
);

    t_in         r_item;
    t_in         n_item;
    logic [7:0]  r_ticks;
    logic [7:0]  n_ticks;
    logic [31:0] r_rf [REG_WORDS];
    logic [31:0] n_rf [REG_WORDS];
    logic [16:0] r_psc;
    logic [16:0] n_psc;
    logic        r_req;
    logic        n_req;
    t_out        r_out;
    t_out        n_out;

    logic [IDX_W-1:0] w_idx;
    logic             w_in_range;
    logic             w_valid;
    logic             w_half;
    logic [31:0]      w_rd;
    logic [16:0]      w_psc_inc;

    assign w_idx      = r_item.byte_offset[IDX_W+1:2];
    assign w_in_range = {1'b0, w_idx} < (IDX_W + 1)'(REG_WORDS);
    assign w_half     = r_item.access_size == SIZE_HALF;
    assign w_valid    = (w_half || r_item.access_size == SIZE_WORD)
                        && ((r_item.byte_offset & ALIGN_MASK) == 12'd0)
                        && (r_item.byte_offset <= LAST_OFFSET);
    assign w_rd       = (r_item.clock_on && w_in_range) ? r_rf[w_idx] : 32'd0;
    assign w_psc_inc  = r_psc + 17'd1;

    assign o_sts.tick_go    = r_item.clock_on && (r_item.action == ACT_TICK)
                              && r_rf[W_CTRL][0];
    assign o_sts.ticks_zero = r_ticks == 8'd0;
    assign o_result         = r_out;

    always_comb begin
        n_item  = r_item;
        n_ticks = r_ticks;
        n_rf    = r_rf;
        n_psc   = r_psc;
        n_req   = r_req;
        n_out   = r_out;

        if (i_cmd.load) begin
            n_item  = i_item;
            n_ticks = i_item.tick_count;
            n_req   = 1'b0;
        end

        if (i_cmd.tick) begin
            n_ticks = r_ticks - 8'd1;
            if (w_psc_inc > {1'b0, r_rf[W_PRESC][15:0]}) begin
                n_psc = 17'd0;
                if (r_rf[W_COUNT] >= {16'd0, r_rf[W_RELOAD][15:0]}) begin
                    n_rf[W_COUNT]     = 32'd0;
                    n_rf[W_STATUS][0] = 1'b1;
                    if (r_rf[W_IE][0]) begin
                        n_req = 1'b1;
                    end
                end else begin
                    n_rf[W_COUNT] = r_rf[W_COUNT] + 32'd1;
                end
            end else begin
                n_psc = w_psc_inc;
            end
        end

        if (i_cmd.finish) begin
            n_out = '0;
            case (r_item.action)
                ACT_READ: begin
                    if (w_valid) begin
                        n_out.access_ok = 1'b1;
                        n_out.read_data = w_half ? (w_rd & LOW16) : w_rd;
                    end
                end
                ACT_WRITE: begin
                    if (w_valid) begin
                        n_out.access_ok = 1'b1;
                        if (r_item.clock_on && w_in_range) begin
                            if (w_idx == W_STATUS) begin
                                n_rf[W_STATUS] = r_rf[W_STATUS] & r_item.write_data;
                            end else if (w_idx == W_EVENT) begin
                                n_rf[W_EVENT] = r_item.write_data;
                                if (r_item.write_data[0]) begin
                                    n_rf[W_COUNT]     = 32'd0;
                                    n_psc             = 17'd0;
                                    n_rf[W_STATUS][0] = 1'b1;
                                end
                            end else begin
                                n_rf[w_idx] = w_half ? (r_item.write_data & LOW16)
                                                     : r_item.write_data;
                            end
                        end
                    end
                end
                ACT_TICK: begin
                    n_out.access_ok      = 1'b1;
                    n_out.update_request = r_req;
                end
                default: begin
                    n_out = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_ticks <= n_ticks;
        r_out   <= n_out;
        if (!i_rst_n) begin
            for (int i = 0; i < REG_WORDS; i++) begin
                r_rf[i] <= 32'd0;
            end
            r_rf[W_RELOAD] <= LOW16;
            r_psc          <= 17'd0;
            r_req          <= 1'b0;
        end else begin
            r_rf  <= n_rf;
            r_psc <= n_psc;
            r_req <= n_req;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && !w_valid && (r_item.action == ACT_READ
            || r_item.action == ACT_WRITE) |=> !r_out.access_ok)
        else $error("bus error not reported");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_item.action != ACT_TICK |=> !r_out.update_request)
        else $error("update request on a bus beat");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick |-> o_sts.tick_go && !o_sts.ticks_zero)
        else $error("tick issued without a running batch");

endmodule

`default_nettype wire
